### src/rffvt_pkg.sv
`default_nettype none
package rffvt_pkg;

	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} pos_t;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_IMAGE_WIDTH    = 3'd2,
		REG_IMAGE_HEIGHT   = 3'd3,
		REG_ASPECT_RATIO   = 3'd4,
		REG_ROTATION_ANGLE = 3'd5,
		REG_FILL_MODE      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [13:0] frame_width;
		logic [13:0] frame_height;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [22:0] aspect_ratio;
		logic [14:0] rotation_angle;
		logic        fill_mode;
	} cfg_t;

	localparam int IMG_W_BITS = 36;
	localparam int BOUND_BITS = 37;
	localparam int SCALE_BITS = 40;

	typedef struct packed {
		logic signed [17:0]    cos_coef;
		logic signed [17:0]    sin_coef;
		logic [SCALE_BITS-1:0] scale_factor;
		logic [IMG_W_BITS-1:0] img_w;
		logic                  valid;
	} coef_t;

	typedef enum logic [2:0] {
		CS_START,
		CS_ROT,
		CS_QUAD,
		CS_MUL,
		CS_BOUND,
		CS_DIV,
		CS_SEL,
		CS_IDLE
	} coef_state_t;

	localparam logic [14:0] ANGLE_FULL    = 15'd23040;
	localparam logic [14:0] ANGLE_QUARTER = 15'd5760;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [17:0] UNIT_COEF = 18'sd65536;
	localparam logic [SCALE_BITS-1:0] SCALE_MAX = {SCALE_BITS{1'b1}};

	// atan(2^-i) in 1/64 degree, scaled by 2^16
	function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
		logic signed [31:0] r;
		unique case (idx)
			5'd0:  r = 32'sd188743680;
			5'd1:  r = 32'sd111421900;
			5'd2:  r = 32'sd58872272;
			5'd3:  r = 32'sd29884485;
			5'd4:  r = 32'sd15000234;
			5'd5:  r = 32'sd7507429;
			5'd6:  r = 32'sd3754631;
			5'd7:  r = 32'sd1877430;
			5'd8:  r = 32'sd938729;
			5'd9:  r = 32'sd469366;
			5'd10: r = 32'sd234683;
			5'd11: r = 32'sd117342;
			5'd12: r = 32'sd58671;
			5'd13: r = 32'sd29335;
			5'd14: r = 32'sd14668;
			5'd15: r = 32'sd7334;
			5'd16: r = 32'sd3667;
			5'd17: r = 32'sd1833;
			5'd18: r = 32'sd917;
			5'd19: r = 32'sd458;
			5'd20: r = 32'sd229;
			5'd21: r = 32'sd115;
			5'd22: r = 32'sd57;
			5'd23: r = 32'sd29;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### src/rffvt_fifo.sv
`default_nettype none
module rffvt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic                  full
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rdata = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q[AW-1:0]] <= wdata;
	end
endmodule
`default_nettype wire

### src/rffvt_coef.sv
`default_nettype none
module rffvt_coef import rffvt_pkg::*; #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic restart,
	input  wire cfg_t cfg,
	output coef_t     coef
);
	localparam int CW = $clog2(TRIG_ITERATIONS);
	localparam int DIV_STEPS = SCALE_BITS;
	localparam int DW = $clog2(DIV_STEPS);

	coef_state_t state_q, state_d;

	logic [CW-1:0]         iter_q;
	logic [DW-1:0]         cnt_q;
	logic                  valid_q;
	logic signed [32:0]    x_q, y_q;
	logic signed [31:0]    z_q;
	logic [1:0]            quad_q;
	logic                  zero_q;
	logic signed [17:0]    cos_q, sin_q;
	logic [IMG_W_BITS-1:0] w_q;
	logic [52:0]           p_cw_q, p_sw_q;
	logic [29:0]           p_sh_q, p_ch_q;
	logic [BOUND_BITS-1:0] bnd_x_q, bnd_y_q, rem_x_q, rem_y_q;
	logic [SCALE_BITS-1:0] quo_x_q, quo_y_q, scale_q;
	logic                  sat_x_q, sat_y_q;

	// angle reduction and quadrant split
	logic [14:0] ang_red, quad_base;
	logic [1:0]  quad;
	always_comb begin
		ang_red = (cfg.rotation_angle >= ANGLE_FULL) ? 15'(cfg.rotation_angle - ANGLE_FULL)
			: cfg.rotation_angle;
		priority if (ang_red < ANGLE_QUARTER) begin
			quad = 2'd0; quad_base = 15'd0;
		end else if (ang_red < 15'(2 * ANGLE_QUARTER)) begin
			quad = 2'd1; quad_base = ANGLE_QUARTER;
		end else if (ang_red < 15'(3 * ANGLE_QUARTER)) begin
			quad = 2'd2; quad_base = 15'(2 * ANGLE_QUARTER);
		end else begin
			quad = 2'd3; quad_base = 15'(3 * ANGLE_QUARTER);
		end
	end
	logic [14:0] ang_in_quad;
	assign ang_in_quad = ang_red - quad_base;

	// one rotation step
	logic signed [32:0] dx, dy;
	logic signed [31:0] at;
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = atan_entry(5'(iter_q));

	function automatic logic signed [17:0] round_unit(input logic signed [32:0] v);
		logic signed [32:0] r;
		logic signed [17:0] o;
		r = (v + 33'sd8192) >>> 14;
		if (r > 33'sd65536)
			o = UNIT_COEF;
		else if (r < -33'sd65536)
			o = -UNIT_COEF;
		else
			o = 18'(r);
		return o;
	endfunction

	logic signed [17:0] c_r, s_r;
	assign c_r = zero_q ? UNIT_COEF : round_unit(x_q);
	assign s_r = zero_q ? 18'sd0 : round_unit(y_q);

	logic [16:0] ac, as_;
	assign ac  = 17'(cos_q[17] ? -cos_q : cos_q);
	assign as_ = 17'(sin_q[17] ? -sin_q : sin_q);

	logic [52:0] sum_bw, sum_bh;
	assign sum_bw = p_cw_q + {7'b0, p_sh_q, 16'b0};
	assign sum_bh = p_sw_q + {7'b0, p_ch_q, 16'b0};

	logic [BOUND_BITS:0] rem2_x, rem2_y;
	logic                ge_x, ge_y;
	assign rem2_x = {rem_x_q, 1'b0};
	assign rem2_y = {rem_y_q, 1'b0};
	assign ge_x   = rem2_x >= {1'b0, bnd_x_q};
	assign ge_y   = rem2_y >= {1'b0, bnd_y_q};

	logic [SCALE_BITS-1:0] sx, sy;
	assign sx = sat_x_q ? SCALE_MAX : quo_x_q;
	assign sy = sat_y_q ? SCALE_MAX : quo_y_q;

	always_comb begin
		state_d = state_q;
		if (restart)
			state_d = CS_START;
		else begin
			unique case (state_q)
				CS_START: state_d = CS_ROT;
				CS_ROT:   if (iter_q == CW'(TRIG_ITERATIONS - 1)) state_d = CS_QUAD;
				CS_QUAD:  state_d = CS_MUL;
				CS_MUL:   state_d = CS_BOUND;
				CS_BOUND: state_d = CS_DIV;
				CS_DIV:   if (cnt_q == DW'(DIV_STEPS - 1)) state_d = CS_SEL;
				CS_SEL:   state_d = CS_IDLE;
				CS_IDLE:  state_d = CS_IDLE;
				default:  state_d = CS_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_START;
			iter_q  <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= (state_q == CS_ROT) ? iter_q + 1'b1 : '0;
			cnt_q   <= (state_q == CS_DIV) ? cnt_q + 1'b1 : '0;
			if (restart)
				valid_q <= 1'b0;
			else if (state_q == CS_SEL)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_START: begin
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= 32'({ang_in_quad, 16'b0});
				quad_q <= quad;
				zero_q <= (ang_in_quad == 15'd0);
				w_q    <= IMG_W_BITS'(cfg.image_width) * IMG_W_BITS'(cfg.aspect_ratio);
			end
			CS_ROT: begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			CS_QUAD: begin
				unique case (quad_q)
					2'd0: begin cos_q <= c_r;  sin_q <= s_r;  end
					2'd1: begin cos_q <= -s_r; sin_q <= c_r;  end
					2'd2: begin cos_q <= -c_r; sin_q <= -s_r; end
					default: begin cos_q <= s_r; sin_q <= -c_r; end
				endcase
			end
			CS_MUL: begin
				p_cw_q <= 53'(ac) * 53'(w_q);
				p_sw_q <= 53'(as_) * 53'(w_q);
				p_sh_q <= 30'(as_) * 30'(cfg.image_height);
				p_ch_q <= 30'(ac) * 30'(cfg.image_height);
			end
			CS_BOUND: begin
				bnd_x_q <= sum_bw[52:16];
				bnd_y_q <= sum_bh[52:16];
				sat_x_q <= sum_bw[52:16] <= BOUND_BITS'(cfg.frame_width);
				sat_y_q <= sum_bh[52:16] <= BOUND_BITS'(cfg.frame_height);
				rem_x_q <= BOUND_BITS'(cfg.frame_width);
				rem_y_q <= BOUND_BITS'(cfg.frame_height);
				quo_x_q <= '0;
				quo_y_q <= '0;
			end
			CS_DIV: begin
				rem_x_q <= ge_x ? BOUND_BITS'(rem2_x - {1'b0, bnd_x_q}) : rem2_x[BOUND_BITS-1:0];
				rem_y_q <= ge_y ? BOUND_BITS'(rem2_y - {1'b0, bnd_y_q}) : rem2_y[BOUND_BITS-1:0];
				quo_x_q <= {quo_x_q[SCALE_BITS-2:0], ge_x};
				quo_y_q <= {quo_y_q[SCALE_BITS-2:0], ge_y};
			end
			CS_SEL: begin
				if (cfg.fill_mode)
					scale_q <= (sx > sy) ? sx : sy;
				else
					scale_q <= (sx < sy) ? sx : sy;
			end
			CS_IDLE: ;
			default: ;
		endcase
	end

	assign coef.cos_coef     = cos_q;
	assign coef.sin_coef     = sin_q;
	assign coef.scale_factor = scale_q;
	assign coef.img_w        = w_q;
	assign coef.valid        = valid_q;
endmodule
`default_nettype wire

### src/rffvt_back.sv
`default_nettype none
module rffvt_back import rffvt_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  issue,
	input  wire vtx_t  item,
	input  wire coef_t coef,
	input  wire cfg_t  cfg,
	output logic       done,
	output pos_t       result
);
	localparam int SH = SCALE_BITS - COORD_FRAC_BITS;
	localparam logic [81:0] HALF = 82'(1) << (SH - 1);
	localparam logic [81:0] P_MAX = 82'(1) << 40;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [53:0] prod_x_s1;
	logic signed [31:0] y16_s1;
	logic signed [55:0] pa_s2 [2];
	logic signed [55:0] pb_s2 [2];
	logic [40:0]        m_s3 [2];
	logic               neg_s3 [2], neg_s4 [2], neg_s5 [2];
	logic [60:0]        hi_s4 [2], lo_s4 [2];
	logic [40:0]        p_s5 [2];
	logic signed [31:0] res_s6 [2];

	logic signed [17:0] u, v;
	assign u = $signed({1'b0, item.tex_u}) - 18'sd32768;
	assign v = $signed({1'b0, item.tex_v}) - 18'sd32768;

	logic signed [37:0] x16;
	assign x16 = prod_x_s1[53:16];

	logic signed [56:0] rsum [2];
	logic signed [40:0] r [2];
	logic [81:0]        acc [2];
	logic [81:0]        shf [2];
	logic signed [42:0] pos [2];
	logic signed [42:0] centre [2];

	always_comb begin
		centre[0] = 43'(cfg.frame_width) <<< (COORD_FRAC_BITS - 1);
		centre[1] = 43'(cfg.frame_height) <<< (COORD_FRAC_BITS - 1);
		rsum[0] = 57'(pa_s2[0]) - 57'(pb_s2[0]);
		rsum[1] = 57'(pa_s2[1]) + 57'(pb_s2[1]);
		for (int i = 0; i < 2; i++) begin
			r[i]   = rsum[i][56:16];
			acc[i] = {1'b0, hi_s4[i], 20'b0} + 82'(lo_s4[i]) + HALF;
			shf[i] = acc[i] >> SH;
			pos[i] = neg_s5[i] ? centre[i] - 43'(p_s5[i]) : centre[i] + 43'(p_s5[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3;  v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s1 <= u * $signed({1'b0, coef.img_w});
		y16_s1    <= v * $signed({1'b0, cfg.image_height});
		pa_s2[0]  <= coef.cos_coef * x16;
		pb_s2[0]  <= coef.sin_coef * y16_s1;
		pa_s2[1]  <= coef.sin_coef * x16;
		pb_s2[1]  <= coef.cos_coef * y16_s1;
		for (int i = 0; i < 2; i++) begin
			neg_s3[i] <= r[i][40];
			m_s3[i]   <= 41'(r[i][40] ? -r[i] : r[i]);
			neg_s4[i] <= neg_s3[i];
			hi_s4[i]  <= 61'(m_s3[i]) * 61'(coef.scale_factor[39:20]);
			lo_s4[i]  <= 61'(m_s3[i]) * 61'(coef.scale_factor[19:0]);
			neg_s5[i] <= neg_s4[i];
			p_s5[i]   <= (shf[i] > P_MAX) ? P_MAX[40:0] : shf[i][40:0];
			if (pos[i] > 43'sd2147483647)
				res_s6[i] <= 32'sh7FFF_FFFF;
			else if (pos[i] < -43'sd2147483648)
				res_s6[i] <= 32'sh8000_0000;
			else
				res_s6[i] <= 32'(pos[i]);
		end
	end

	assign done            = v_s6;
	assign result.screen_x = res_s6[0];
	assign result.screen_y = res_s6[1];
endmodule
`default_nettype wire

### src/rotated_fit_fill_vertex_transform.sv
// Rotated fit/fill vertex transform.
// Input queue: push/full carries vtx (tex_u, tex_v, unsigned Q1.16); an item is
// taken on a clock edge with push high and full low.
// Result queue: empty/pop carries pos (screen_x, screen_y, signed Q.8, saturated);
// the oldest result shows while empty is low and leaves on pop with empty low.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per cycle;
// unknown indexes are ignored. Every write to a known index restarts
// coefficient generation, which runs a CORDIC loop and then a 40-step restoring
// divider; vertices wait in the input queue until it ends.
// The same sequence runs once after reset, with the register reset values.
// A vertex passes the input queue, then a six-stage multiply pipeline. Throughput
// is one vertex per cycle while coefficients are valid and credit remains.
// Issue into the pipeline is credited against the eight-entry result queue, so
// when pop stays low the pipeline drains into it and full rises once both
// queues fill; nothing is dropped.
// Asynchronous active-low reset empties both queues and clears the pipeline.
`default_nettype none
module rotated_fit_fill_vertex_transform import rffvt_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire vtx_t        vtx,
	output logic             empty,
	input  wire logic        pop,
	output pos_t             pos,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [22:0] cfg_data
);
	localparam int IN_DEPTH  = 4;
	localparam int OUT_DEPTH = 8;
	localparam int CRW = $clog2(OUT_DEPTH + 1);

	cfg_t  cfg_q;
	coef_t coef;
	logic  restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= 14'd1920;
			cfg_q.frame_height   <= 14'd1080;
			cfg_q.image_width    <= 13'd1;
			cfg_q.image_height   <= 13'd1;
			cfg_q.aspect_ratio   <= 23'd65536;
			cfg_q.rotation_angle <= 15'd0;
			cfg_q.fill_mode      <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data[13:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data[13:0];
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[12:0];
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[12:0];
				REG_ASPECT_RATIO:   cfg_q.aspect_ratio   <= cfg_data;
				REG_ROTATION_ANGLE: cfg_q.rotation_angle <= cfg_data[14:0];
				REG_FILL_MODE:      cfg_q.fill_mode      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_wr_en && (cfg_index <= REG_FILL_MODE);

	rffvt_coef #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_coef (
		.clk(clk), .arst_n(arst_n), .restart(restart), .cfg(cfg_q), .coef(coef)
	);

	// front: input queue
	vtx_t in_item;
	logic in_empty, issue;
	logic [CRW-1:0] credit_q;

	assign issue = coef.valid && !in_empty && (credit_q < CRW'(OUT_DEPTH));

	rffvt_fifo #(.WIDTH($bits(vtx_t)), .DEPTH(IN_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(vtx), .pop(issue),
		.rdata(in_item), .empty(in_empty), .full(full)
	);

	// back: transform pipeline and result queue
	logic done, out_full, out_pop;
	pos_t result;

	rffvt_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .issue(issue), .item(in_item), .coef(coef),
		.cfg(cfg_q), .done(done), .result(result)
	);

	rffvt_fifo #(.WIDTH($bits(pos_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(done), .wdata(result), .pop(pop),
		.rdata(pos), .empty(empty), .full(out_full)
	);

	assign out_pop = pop && !empty;

	// credit counts vertices in the pipeline plus those held in the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			credit_q <= '0;
		else if (issue && !out_pop)
			credit_q <= credit_q + 1'b1;
		else if (!issue && out_pop)
			credit_q <= credit_q - 1'b1;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_full)
		else $error("result queue written while full");
	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRW'(OUT_DEPTH))
		else $error("credit count out of range");
	a_issue_valid: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> coef.valid)
		else $error("vertex issued with stale coefficients");
	a_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !coef.valid)
		else $error("coefficients stayed valid after a register write");
`endif
endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rffvt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	vtx_t        vtx = '0;
	logic        empty;
	logic        pop = 1'b0;
	pos_t        pos;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;

	localparam int FRAC = 8;
	localparam int ITERS = 16;

	rotated_fit_fill_vertex_transform #(
		.COORD_FRAC_BITS(FRAC),
		.TRIG_ITERATIONS(ITERS)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .vtx(vtx),
		.empty(empty), .pop(pop), .pos(pos),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the registers and derived coefficients
	logic [13:0] sh_frame_w = 14'd1920, sh_frame_h = 14'd1080;
	logic [12:0] sh_img_w = 13'd1, sh_img_h = 13'd1;
	logic [22:0] sh_aspect = 23'd65536;
	logic [14:0] sh_angle = '0;
	logic        sh_fill = 1'b0;
	longint      cos_q16, sin_q16;
	longint unsigned scale_q24;
	bit          coefs_fresh = 1'b0;

	pos_t   expected_pos[$];
	int     mismatches = 0;
	bit     stall_mode = 1'b0;
	int     burst_left = 0;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic longint atan_q16(int i);
		longint t[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
			3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
			3667, 1833, 917, 458, 229, 115, 57, 29};
		return t[i];
	endfunction

	function automatic longint unsigned frame_ratio(longint unsigned frame,
			longint unsigned bound);
		longint unsigned q;
		if (bound == 0) return 64'hFF_FFFF_FFFF;
		q = (frame << 40) / bound;
		return (q > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : q;
	endfunction

	task automatic derive_coefs();
		longint unsigned ang, quad, a, w, h, ac, as, bw, bh, sx, sy;
		longint x, y, z, dx, dy, c, s;
		ang = 64'(sh_angle);
		if (ang >= 23040) ang -= 23040;
		quad = ang / 5760;
		a = ang - quad * 5760;
		if (a == 0) begin
			c = 65536; s = 0;
		end else begin
			x = 652032874; y = 0; z = longint'(a) << 16;
			for (int i = 0; i < ITERS && i < 24; i++) begin
				dx = floor_shr(y, i); dy = floor_shr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_q16(i);
				end else begin
					x += dx; y -= dy; z += atan_q16(i);
				end
			end
			c = unit_clamp(floor_shr(x + 8192, 14));
			s = unit_clamp(floor_shr(y + 8192, 14));
		end
		case (quad)
			0: begin cos_q16 = c;  sin_q16 = s;  end
			1: begin cos_q16 = -s; sin_q16 = c;  end
			2: begin cos_q16 = -c; sin_q16 = -s; end
			default: begin cos_q16 = s; sin_q16 = -c; end
		endcase
		w = longint'(sh_img_w) * longint'(sh_aspect);
		h = longint'(sh_img_h) << 16;
		ac = (cos_q16 < 0) ? -cos_q16 : cos_q16;
		as = (sin_q16 < 0) ? -sin_q16 : sin_q16;
		bw = (ac * w + as * h) >> 16;
		bh = (as * w + ac * h) >> 16;
		sx = frame_ratio(64'(sh_frame_w), bw);
		sy = frame_ratio(64'(sh_frame_h), bh);
		scale_q24 = sh_fill ? ((sx > sy) ? sx : sy) : ((sx < sy) ? sx : sy);
		coefs_fresh = 1'b1;
	endtask

	function automatic logic [31:0] place_coord(longint r, longint unsigned frame);
		localparam int SH = 40 - FRAC;
		longint unsigned m, hi, lo, ahi, alo, p;
		longint centre, v;
		m = (r < 0) ? -r : r;
		hi = m * (scale_q24 >> 20);
		lo = m * (scale_q24 & 64'hFFFFF);
		ahi = hi >> (SH - 20);
		alo = hi & ((64'd1 << (SH - 20)) - 1);
		p = ahi + (((alo << 20) + lo + (64'd1 << (SH - 1))) >> SH);
		if (p > (64'd1 << 40)) p = 64'd1 << 40;
		centre = longint'(frame) << (FRAC - 1);
		v = (r < 0) ? centre - longint'(p) : centre + longint'(p);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic pos_t transform_vertex(vtx_t t);
		longint u, v, w, h, x16, y16, rx, ry;
		pos_t r;
		u = longint'(t.tex_u) - 32768;
		v = longint'(t.tex_v) - 32768;
		w = longint'(sh_img_w) * longint'(sh_aspect);
		h = longint'(sh_img_h) << 16;
		x16 = floor_shr(u * w, 16);
		y16 = floor_shr(v * h, 16);
		rx = floor_shr(cos_q16 * x16 - sin_q16 * y16, 16);
		ry = floor_shr(sin_q16 * x16 + cos_q16 * y16, 16);
		r.screen_x = place_coord(rx, 64'(sh_frame_w));
		r.screen_y = place_coord(ry, 64'(sh_frame_h));
		return r;
	endfunction

	// receiver: stall on its own pattern, check each transfer
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d", pos.screen_x, pos.screen_y);
			end else begin
				pos_t e;
				e = expected_pos.pop_front();
				if (pos.screen_x !== e.screen_x || pos.screen_y !== e.screen_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							e.screen_x, e.screen_y, pos.screen_x, pos.screen_y);
				end
			end
		end
		if (stall_mode) pop <= ($urandom_range(0, 3) != 0);
		else pop <= 1'b1;
	end

	// push stays high through a burst; drop it only for a gap
	task automatic send_vertex(logic [16:0] u, logic [16:0] v);
		vtx_t t;
		int   gap;
		if (burst_left == 0) begin
			gap = stall_mode ? int'($urandom_range(0, 6)) : 0;
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 12));
		end
		burst_left--;
		t.tex_u = u;
		t.tex_v = v;
		push <= 1'b1;
		vtx <= t;
		@(posedge clk);
		while (full) @(posedge clk);
		if (!coefs_fresh) derive_coefs();
		expected_pos.push_back(transform_vertex(t));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_pos.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [22:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:    sh_frame_w = value[13:0];
			REG_FRAME_HEIGHT:   sh_frame_h = value[13:0];
			REG_IMAGE_WIDTH:    sh_img_w = value[12:0];
			REG_IMAGE_HEIGHT:   sh_img_h = value[12:0];
			REG_ASPECT_RATIO:   sh_aspect = value;
			REG_ROTATION_ANGLE: sh_angle = value[14:0];
			REG_FILL_MODE:      sh_fill = value[0];
			default: ;
		endcase
		coefs_fresh = 1'b0;
	endtask

	task automatic send_corners();
		send_vertex(17'd0, 17'd0);
		send_vertex(17'd65536, 17'd0);
		send_vertex(17'd0, 17'd65536);
		send_vertex(17'd65536, 17'd65536);
		send_vertex(17'd32768, 17'd32768);
	endtask

	task automatic test_reset_defaults();
		send_corners();
		send_vertex(17'h1FFFF, 17'h1FFFF);
	endtask

	task automatic test_directed_extremes();
		write_reg(REG_IMAGE_WIDTH, 23'd4096);
		write_reg(REG_IMAGE_HEIGHT, 23'd3000);
		write_reg(REG_ASPECT_RATIO, 23'd6553600);
		write_reg(REG_FRAME_WIDTH, 23'd8192);
		write_reg(REG_FRAME_HEIGHT, 23'd8192);
		write_reg(REG_FILL_MODE, 23'd1);
		write_reg(REG_ROTATION_ANGLE, 23'd5760);
		send_corners();
		// angle beyond a full turn, zero sizes, unknown index
		write_reg(REG_ROTATION_ANGLE, 23'd32767);
		write_reg(REG_IMAGE_WIDTH, 23'd0);
		write_reg(REG_FRAME_HEIGHT, 23'd0);
		write_reg(reg_idx_t'(3'd7), 23'h7FFFFF);
		send_corners();
		write_reg(REG_ASPECT_RATIO, 23'd0);
		write_reg(REG_FILL_MODE, 23'd0);
		write_reg(REG_ROTATION_ANGLE, 23'd11520);
		send_vertex(17'h1FFFF, 17'd0);
		send_vertex(17'd0, 17'h1FFFF);
	endtask

	task automatic random_config();
		write_reg(REG_FRAME_WIDTH, 23'($urandom_range(0, 16383)));
		write_reg(REG_FRAME_HEIGHT, 23'($urandom_range(0, 16383)));
		write_reg(REG_IMAGE_WIDTH, 23'($urandom_range(0, 5) == 0 ?
			$urandom_range(0, 8191) : $urandom_range(1, 4096)));
		write_reg(REG_IMAGE_HEIGHT, 23'($urandom_range(1, 8191)));
		write_reg(REG_ASPECT_RATIO, 23'($urandom_range(0, 4) == 0 ?
			$urandom & 32'h7FFFFF : $urandom_range(16384, 262144)));
		write_reg(REG_ROTATION_ANGLE, 23'($urandom_range(0, 3) == 0 ?
			5760 * $urandom_range(0, 5) : $urandom_range(0, 32767)));
		write_reg(REG_FILL_MODE, 23'($urandom_range(0, 1)));
	endtask

	task automatic test_random_vertices();
		for (int phase = 0; phase < 20; phase++) begin
			random_config();
			stall_mode = (phase % 4 != 0);
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_vertex(17'($urandom), 17'($urandom));
				else
					send_vertex(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_extremes();
		test_random_vertices();
		drain();
		if (mismatches == 0 && expected_pos.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
src/rffvt_pkg.sv
src/rffvt_fifo.sv
src/rffvt_coef.sv
src/rffvt_back.sv
src/rotated_fit_fill_vertex_transform.sv
sim/testbench.sv
